// ----- rtl/core/vrst_pkg.sv -----
// Shared types, widths and the quarter-wave sine table for the vertex transform.
// No dependencies; used by every module of the block.
`default_nettype none

package vrst_pkg;

  localparam int FIELD_W          = 32;
  localparam int COORD_WIDTH      = 32;
  localparam int CW               = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int TRIG_TABLE_DEPTH = 1024;

  localparam int ANGLE_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int TRIG_IDX_W = $clog2(TRIG_TABLE_DEPTH);
  localparam int STEP_SH    = ANGLE_W - TRIG_IDX_W;
  localparam int PHASE_STEP = 65536 / TRIG_TABLE_DEPTH;
  localparam int QE         = TRIG_TABLE_DEPTH / 4;
  localparam int QIDX_W     = $clog2(QE) + 1;
  localparam int QUARTER    = 16384;
  localparam int QSIN_W     = 15;

  localparam logic [ANGLE_W-1:0] PHASE_MASK = ANGLE_W'(16'hFFFF << STEP_SH);

  // datapath widths
  localparam int PROD_W  = CW + TRIG_W;
  localparam int ROT_W   = PROD_W + 1;
  localparam int SPROD_W = ROT_W + SCALE_W;
  localparam int ACC_W   = SPROD_W + 1;
  localparam int FRAC_SH = 22;
  localparam int RND_W   = ACC_W - FRAC_SH;

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_SCALE_X   = 3'd2,
    REG_SCALE_Y   = 3'd3,
    REG_ROT_ANGLE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CW-1:0]      pos_x;
    logic [CW-1:0]      pos_y;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [TRIG_W-1:0]  sin_v;
    logic [TRIG_W-1:0]  cos_v;
  } xform_cfg_t;

  typedef logic [QSIN_W-1:0] qsin_tbl_t [0:QE];

  // 9th order odd polynomial in Q30, evaluated once at elaboration
  function automatic qsin_tbl_t build_qsin();
    qsin_tbl_t   tbl;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int i = 0; i <= QE; i++) begin
      z  = 64'(i * PHASE_STEP) << 16;
      z2 = (z * z) >> 30;
      t  = 64'd172271;
      t  = 64'd5026995    - ((z2 * t) >> 30);
      t  = 64'd85569306   - ((z2 * t) >> 30);
      t  = 64'd693598668  - ((z2 * t) >> 30);
      t  = 64'd1686629713 - ((z2 * t) >> 30);
      s  = (z * t) >> 30;
      r  = (s + 64'd32768) >> 16;
      if (r > 64'(QUARTER)) begin
        r = 64'(QUARTER);
      end
      tbl[i] = r[QSIN_W-1:0];
    end
    return tbl;
  endfunction

  localparam qsin_tbl_t QSIN_TBL = build_qsin();

  function automatic logic [TRIG_W-1:0] phase_sine(input logic [ANGLE_W-1:0] phase);
    logic [QIDX_W-1:0] qi;
    logic [TRIG_W-1:0] m;
    qi = QIDX_W'(phase[13:STEP_SH]);
    if (phase[14]) begin
      qi = QIDX_W'(QE) - qi;
    end
    m = TRIG_W'(QSIN_TBL[qi]);
    return phase[15] ? (TRIG_W'(0) - m) : m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vrst_cfg_regs.sv -----
// Configuration registers and sine/cosine lookup on angle writes.
// Depends on vrst_pkg.
`default_nettype none

module vrst_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vrst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vrst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output vrst_pkg::xform_cfg_t            cfg_o
);

  vrst_pkg::xform_cfg_t             cfg_d, cfg_q;
  logic [vrst_pkg::ANGLE_W-1:0]     phase;

  assign phase = cfg_wdata_i[vrst_pkg::ANGLE_W-1:0] & vrst_pkg::PHASE_MASK;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (vrst_pkg::cfg_reg_e'(cfg_idx_i))
        vrst_pkg::REG_POS_X:   cfg_d.pos_x   = cfg_wdata_i[vrst_pkg::CW-1:0];
        vrst_pkg::REG_POS_Y:   cfg_d.pos_y   = cfg_wdata_i[vrst_pkg::CW-1:0];
        vrst_pkg::REG_SCALE_X: cfg_d.scale_x = cfg_wdata_i[vrst_pkg::SCALE_W-1:0];
        vrst_pkg::REG_SCALE_Y: cfg_d.scale_y = cfg_wdata_i[vrst_pkg::SCALE_W-1:0];
        vrst_pkg::REG_ROT_ANGLE: begin
          cfg_d.sin_v = vrst_pkg::phase_sine(phase);
          cfg_d.cos_v = vrst_pkg::phase_sine(phase + vrst_pkg::ANGLE_W'(vrst_pkg::QUARTER));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= '0;
      cfg_q.pos_y   <= '0;
      cfg_q.scale_x <= vrst_pkg::SCALE_W'(256);
      cfg_q.scale_y <= vrst_pkg::SCALE_W'(256);
      cfg_q.sin_v   <= '0;
      cfg_q.cos_v   <= vrst_pkg::TRIG_W'(vrst_pkg::QUARTER);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/vrst_pipe.sv -----
// Five-stage transform pipeline: trig products, rotate sum, scale product,
// translate and round, saturate. Depends on vrst_pkg.
`default_nettype none

module vrst_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vrst_pkg::xform_cfg_t        cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [vrst_pkg::CW-1:0] vec_x_i,
  input  logic signed [vrst_pkg::CW-1:0] vec_y_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [vrst_pkg::CW-1:0] point_x_o,
  output logic signed [vrst_pkg::CW-1:0] point_y_o,
  output logic                        last_o,
  output logic                        sat_o
);

  localparam int CW      = vrst_pkg::CW;
  localparam int PROD_W  = vrst_pkg::PROD_W;
  localparam int ROT_W   = vrst_pkg::ROT_W;
  localparam int SPROD_W = vrst_pkg::SPROD_W;
  localparam int ACC_W   = vrst_pkg::ACC_W;
  localparam int RND_W   = vrst_pkg::RND_W;
  localparam int FRAC_SH = vrst_pkg::FRAC_SH;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_SH - 1);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic l1_q, l2_q, l3_q, l4_q, l5_q;

  logic signed [PROD_W-1:0]  xc_d, ys_d, xs_d, yc_d, xc_q, ys_q, xs_q, yc_q;
  logic signed [ROT_W-1:0]   rx_d, ry_d, rx_q, ry_q;
  logic signed [SPROD_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [ACC_W-1:0]   ax, ay;
  logic signed [RND_W-1:0]   nx_d, ny_d, nx_q, ny_q;
  logic signed [CW-1:0]      px_d, py_d, px_q, py_q;
  logic                      ovx, ovy, sat_q;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: vector by sine and cosine
  assign xc_d = PROD_W'(vec_x_i) * PROD_W'($signed(cfg_i.cos_v));
  assign ys_d = PROD_W'(vec_y_i) * PROD_W'($signed(cfg_i.sin_v));
  assign xs_d = PROD_W'(vec_x_i) * PROD_W'($signed(cfg_i.sin_v));
  assign yc_d = PROD_W'(vec_y_i) * PROD_W'($signed(cfg_i.cos_v));

  // stage 2: rotation sums
  assign rx_d = ROT_W'(xc_q) - ROT_W'(ys_q);
  assign ry_d = ROT_W'(xs_q) + ROT_W'(yc_q);

  // stage 3: per-axis scale
  assign sx_d = SPROD_W'(rx_q) * SPROD_W'($signed(cfg_i.scale_x));
  assign sy_d = SPROD_W'(ry_q) * SPROD_W'($signed(cfg_i.scale_y));

  // stage 4: translate, round half up to Q16.16
  assign ax   = ACC_W'(sx_q) + (ACC_W'($signed(cfg_i.pos_x)) <<< FRAC_SH) + RND_BIAS;
  assign ay   = ACC_W'(sy_q) + (ACC_W'($signed(cfg_i.pos_y)) <<< FRAC_SH) + RND_BIAS;
  assign nx_d = ax[ACC_W-1:FRAC_SH];
  assign ny_d = ay[ACC_W-1:FRAC_SH];

  // stage 5: saturate
  assign ovx  = !((&nx_q[RND_W-1:CW-1]) || !(|nx_q[RND_W-1:CW-1]));
  assign ovy  = !((&ny_q[RND_W-1:CW-1]) || !(|ny_q[RND_W-1:CW-1]));
  assign px_d = ovx ? (nx_q[RND_W-1] ? vrst_pkg::SAT_MIN : vrst_pkg::SAT_MAX) : nx_q[CW-1:0];
  assign py_d = ovy ? (ny_q[RND_W-1] ? vrst_pkg::SAT_MIN : vrst_pkg::SAT_MAX) : ny_q[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      xc_q <= xc_d;
      ys_q <= ys_d;
      xs_q <= xs_d;
      yc_q <= yc_d;
      l1_q <= last_i;
    end
    if (en2) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      l2_q <= l1_q;
    end
    if (en3) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      l3_q <= l2_q;
    end
    if (en4) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      l4_q <= l3_q;
    end
    if (en5) begin
      px_q  <= px_d;
      py_q  <= py_d;
      sat_q <= ovx || ovy;
      l5_q  <= l4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign last_o      = l5_q;
  assign sat_o       = sat_q;

endmodule

`default_nettype wire

// ----- rtl/core/vertex_rotate_scale_translate_unit.sv -----
// Throughput: one vertex per cycle while the output is ready; the five-stage pipeline
// compresses bubbles and each stage holds its request while the next is full.
// Reset: all stage valid bits clear, position 0, scales 1.0, angle 0
// (sine 0, cosine 1.0). Top level: config registers plus transform pipeline.
`default_nettype none

module vertex_rotate_scale_translate_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vrst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vrst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // vec_x, vec_y
  input  logic                            s_axis_tlast,  // last_vertex
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // point_x, point_y
  output logic                            m_axis_tlast,  // last_point
  output logic                            m_axis_tuser   // saturated
);

  localparam int CW = vrst_pkg::CW;
  localparam int FW = vrst_pkg::FIELD_W;

  vrst_pkg::xform_cfg_t    cfg;
  logic signed [CW-1:0]    vec_x, vec_y, point_x, point_y;

  assign vec_x = s_axis_tdata[CW-1:0];
  assign vec_y = s_axis_tdata[FW +: CW];

  vrst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vrst_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .last_o      (m_axis_tlast),
    .sat_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {FW'(point_y), FW'(point_x)};

endmodule

`default_nettype wire

// ----- rtl/core/vrst_checker.sv -----
// Port-level checks for the vertex transform and the bind onto its top level.
// Depends on vrst_pkg and vertex_rotate_scale_translate_unit.
`default_nettype none

module vrst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  localparam logic [31:0] PT_MAX = 32'(vrst_pkg::SAT_MAX);
  localparam logic [31:0] PT_MIN = 32'(vrst_pkg::SAT_MIN);

  // empty output stage means the whole pipe can advance
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_flow_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[31:0] == PT_MAX || m_axis_tdata[31:0] == PT_MIN ||
       m_axis_tdata[63:32] == PT_MAX || m_axis_tdata[63:32] == PT_MIN))
    else $error("saturated flag without a clipped coordinate");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled output request changed");

endmodule

bind vertex_rotate_scale_translate_unit vrst_checker u_vrst_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench for the vertex rotate/scale/translate unit: stream requests in and
// compare every point against a local bit-exact transform model. Depends on vrst_pkg
// and vertex_rotate_scale_translate_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY       = 5;
  localparam int SETTLE_CYCLES = LATENCY + 3;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int ITEMS_PER_SET = 125;
  localparam int FRAC_BITS     = 22;

  localparam logic [vrst_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [vrst_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [63:0] COEF_C1 = 64'd1686629713;
  localparam logic [63:0] COEF_C3 = 64'd693598668;
  localparam logic [63:0] COEF_C5 = 64'd85569306;
  localparam logic [63:0] COEF_C7 = 64'd5026995;
  localparam logic [63:0] COEF_C9 = 64'd172271;
  localparam int unsigned QUARTER_TURN = 16384;

  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic        last_point;
    logic        saturated;
  } point_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [vrst_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [vrst_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [63:0]                     s_axis_tdata;  // vec_x, vec_y
  logic                            s_axis_tlast;  // last_vertex
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [63:0]                     m_axis_tdata;  // point_x, point_y
  logic                            m_axis_tlast;  // last_point
  logic                            m_axis_tuser;  // saturated

  vertex_rotate_scale_translate_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // transform state mirrored from register writes
  logic signed [31:0] pos_x_q;
  logic signed [31:0] pos_y_q;
  logic signed [15:0] scale_x_q;
  logic signed [15:0] scale_y_q;
  logic [15:0]        angle_q;
  logic signed [15:0] trig_sin;
  logic signed [15:0] trig_cos;

  point_t pending_points[$];
  int     mismatches;
  int     points_checked;
  int     vertices_sent;
  int     reg_writes;
  int     saturated_seen;
  int     cycle_count;
  int     sender_idle_pct;
  int     sink_stall_pct;

  always #10 clk_i = ~clk_i;

  // sine over one quarter turn, q in 0..16384, Q1.14
  function automatic logic signed [15:0] wave_quarter(int unsigned q);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    z  = 64'(q) << 16;
    z2 = (z * z) >> 30;
    t  = COEF_C9;
    t  = COEF_C7 - ((z2 * t) >> 30);
    t  = COEF_C5 - ((z2 * t) >> 30);
    t  = COEF_C3 - ((z2 * t) >> 30);
    t  = COEF_C1 - ((z2 * t) >> 30);
    s  = (z * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'(QUARTER_TURN)) begin
      r = 64'(QUARTER_TURN);
    end
    return $signed(r[15:0]);
  endfunction

  function automatic logic signed [15:0] wave_sine(logic [15:0] phase);
    logic signed [15:0] m;
    int unsigned        q;
    q = int'(phase[13:0]);
    m = phase[14] ? wave_quarter(QUARTER_TURN - q) : wave_quarter(q);
    return phase[15] ? -m : m;
  endfunction

  function automatic void load_trig(logic [15:0] angle);
    logic [63:0] idx;
    logic [63:0] ph;
    idx = (64'(angle) * 64'(vrst_pkg::TRIG_TABLE_DEPTH)) >> 16;
    ph  = (idx * 64'd65536) / 64'(vrst_pkg::TRIG_TABLE_DEPTH);
    trig_sin = wave_sine(ph[15:0]);
    trig_cos = wave_sine(ph[15:0] + 16'(QUARTER_TURN));
  endfunction

  function automatic void apply_reg_write(logic [vrst_pkg::CFG_IDX_W-1:0] idx,
                                          logic [31:0] val);
    case (idx)
      vrst_pkg::REG_POS_X:     pos_x_q = $signed(val[vrst_pkg::CW-1:0]);
      vrst_pkg::REG_POS_Y:     pos_y_q = $signed(val[vrst_pkg::CW-1:0]);
      vrst_pkg::REG_SCALE_X:   scale_x_q = $signed(val[15:0]);
      vrst_pkg::REG_SCALE_Y:   scale_y_q = $signed(val[15:0]);
      vrst_pkg::REG_ROT_ANGLE: begin
        angle_q = val[15:0];
        load_trig(angle_q);
      end
      default: ;
    endcase
  endfunction

  // round half up from Q.38 to Q16.16, then clip to the coordinate width
  function automatic logic [31:0] round_clip(input logic signed [79:0] acc, inout logic sat);
    logic signed [79:0] v;
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    v  = (acc + 80'sd2097152) >>> FRAC_BITS;
    hi = (80'sd1 <<< (vrst_pkg::CW - 1)) - 80'sd1;
    lo = -(80'sd1 <<< (vrst_pkg::CW - 1));
    if (v > hi) begin
      sat = 1'b1;
      v   = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v   = lo;
    end
    return v[31:0];
  endfunction

  function automatic point_t transform_vertex(logic [31:0] vx_raw, logic [31:0] vy_raw,
                                              logic last);
    point_t             p;
    logic signed [79:0] vx;
    logic signed [79:0] vy;
    logic signed [79:0] cs;
    logic signed [79:0] sn;
    logic signed [79:0] sx;
    logic signed [79:0] sy;
    logic signed [79:0] ox;
    logic signed [79:0] oy;
    logic signed [79:0] rx;
    logic signed [79:0] ry;
    logic               sat;
    vx  = $signed(vx_raw[vrst_pkg::CW-1:0]);
    vy  = $signed(vy_raw[vrst_pkg::CW-1:0]);
    cs  = trig_cos;
    sn  = trig_sin;
    sx  = scale_x_q;
    sy  = scale_y_q;
    ox  = pos_x_q;
    oy  = pos_y_q;
    rx  = vx * cs - vy * sn;
    ry  = vx * sn + vy * cs;
    sat = 1'b0;
    p.point_x    = round_clip(rx * sx + (ox <<< FRAC_BITS), sat);
    p.point_y    = round_clip(ry * sy + (oy <<< FRAC_BITS), sat);
    p.last_point = last;
    p.saturated  = sat;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_points.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unrequested point", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (m_axis_tdata[31:0] !== want.point_x) begin
          report_mismatch("point_x", m_axis_tdata[31:0], want.point_x);
        end
        if (m_axis_tdata[63:32] !== want.point_y) begin
          report_mismatch("point_y", m_axis_tdata[63:32], want.point_y);
        end
        if (m_axis_tlast !== want.last_point) begin
          report_mismatch("last_point", 32'(m_axis_tlast), 32'(want.last_point));
        end
        if (m_axis_tuser !== want.saturated) begin
          report_mismatch("saturated", 32'(m_axis_tuser), 32'(want.saturated));
        end
        if (want.saturated) begin
          saturated_seen++;
        end
      end
    end
  end

  // entered and left at a falling edge; tvalid stays high on return
  task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vy, vx};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    pending_points.push_back(transform_vertex(vx, vy, last));
    vertices_sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_requests();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_register(logic [vrst_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_setting(logic [31:0] px, logic [31:0] py, logic [15:0] sx,
                              logic [15:0] sy, logic [15:0] angle);
    finish_requests();
    load_register(vrst_pkg::REG_POS_X, px);
    load_register(vrst_pkg::REG_POS_Y, py);
    load_register(vrst_pkg::REG_SCALE_X, 32'(sx));
    load_register(vrst_pkg::REG_SCALE_Y, 32'(sy));
    load_register(vrst_pkg::REG_ROT_ANGLE, 32'(angle));
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      0: v = COORD_MAX;
      1: v = COORD_MIN;
      2: v = 32'h0;
      3: v = 32'hFFFF_FFFF;
      4, 5: ;
      default: v = {{8{v[23]}}, v[23:0]};
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_scale();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2, 3: ;
      default: v = 16'sd256 + 16'($signed(v[9:0]));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(7))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = 16'(QUARTER_TURN) * 16'($urandom_range(3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_identity_at_reset();
    send_vertex(32'h0, 32'h0, 1'b0);
    send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
  endtask

  task automatic test_rounding_and_mirror();
    // half scale puts a single raw unit exactly on the rounding midpoint
    load_setting(32'h0, 32'h0, 16'sd128, -16'sd256, 16'h0);
    send_vertex(32'h0000_0001, 32'h0000_0001, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
    load_setting(32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'h0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
  endtask

  task automatic test_rotation_angles();
    logic [15:0] angles[6];
    angles = '{16'(QUARTER_TURN), 16'h8000, 16'hC000, 16'hFFFF, 16'h0001, 16'd12345};
    load_setting(32'h0, 32'h0, 16'sd256, 16'sd256, 16'h0);
    foreach (angles[i]) begin
      finish_requests();
      load_register(vrst_pkg::REG_ROT_ANGLE, 32'(angles[i]));
      send_vertex(32'h0001_0000, 32'h0002_0000, 1'b1);
    end
    // writes past the register list must leave the transform alone
    finish_requests();
    load_register(REG_UNUSED_LO, 32'hFFFF_FFFF);
    load_register(REG_UNUSED_HI, 32'h8000_0000);
    send_vertex(32'h0003_0000, 32'hFFFD_0000, 1'b0);
  endtask

  task automatic test_position_extremes();
    load_setting(COORD_MAX, COORD_MIN, 16'sd256, 16'sd256, 16'd8192);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(32'h0, 32'h0, 1'b0);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 1'b1);
  endtask

  task automatic test_random_polygons(int src_idle, int snk_stall);
    int   remaining;
    int   n;
    logic noisy;
    logic last;
    sender_idle_pct = src_idle;
    sink_stall_pct  = snk_stall;
    for (int s = 0; s < 3; s++) begin
      load_setting(rand_coord(), rand_coord(), rand_scale(), rand_scale(), pick_angle());
      remaining = ITEMS_PER_SET;
      while (remaining > 0) begin
        n     = $urandom_range(8, 3);
        noisy = ($urandom_range(9) == 0);
        for (int i = 0; i < n && remaining > 0; i++) begin
          last = noisy ? 1'($urandom_range(1)) : (i == n - 1);
          send_vertex(rand_coord(), rand_coord(), last);
          remaining--;
        end
      end
    end
    finish_requests();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = vrst_pkg::REG_POS_X;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    m_axis_tready   = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    mismatches      = 0;
    points_checked  = 0;
    vertices_sent   = 0;
    reg_writes      = 0;
    saturated_seen  = 0;
    cycle_count     = 0;
    pos_x_q         = '0;
    pos_y_q         = '0;
    scale_x_q       = 16'sd256;
    scale_y_q       = 16'sd256;
    angle_q         = '0;
    load_trig(16'h0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_identity_at_reset();
    test_rounding_and_mirror();
    test_rotation_angles();
    test_position_extremes();
    test_random_polygons(0, 0);
    test_random_polygons(55, 0);
    test_random_polygons(0, 55);
    test_random_polygons(36, 36);
    finish_requests();

    $display("Sent %0d vertices, checked %0d points (%0d clipped), %0d register writes",
             vertices_sent, points_checked, saturated_seen, reg_writes);
    $display("Covered rounding, mirroring, quadrant angles and four request pressure mixes");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
